/* rtl/hidkb_pkg.sv */
// ----------------------------------------------------------------------------
// hidkb_pkg
// Shared types and usage codes for the HID boot keyboard report builder.
// ----------------------------------------------------------------------------
package hidkb_pkg;

    localparam int REPORT_SLOTS_DEF = 6;   // key slots used by the report
    localparam int OUT_SLOTS        = 6;   // key slots in a boot report
    localparam int USAGE_W          = 8;

    typedef logic [USAGE_W-1:0] usage_t;

    // One boot keyboard report, modifier byte in the lowest bits
    typedef struct packed {
        usage_t [OUT_SLOTS-1:0] slots;
        usage_t                 modifier;
    } report_t;

    // Modifier usages 0xE0..0xE7 share their top five bits
    localparam logic [4:0] USAGE_MOD_PREFIX = 5'b11100;

    localparam usage_t USAGE_LSHIFT = 8'hE1;
    localparam usage_t USAGE_RSHIFT = 8'hE5;
    localparam usage_t USAGE_RIGHT  = 8'h4F;
    localparam usage_t USAGE_LEFT   = 8'h50;
    localparam usage_t USAGE_DOWN   = 8'h51;
    localparam usage_t USAGE_UP     = 8'h52;

endpackage

/* rtl/hid_keyboard_report_builder_top.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_top
// Builds one 7-byte boot keyboard report (reserved byte omitted) per scan.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (lowest bit up)                    | tuser/tlast
//  ---------+-----------+------------------------------------------+-------------
//  s_       | in        | key_code[7:0]                            | tlast = last_key
//  m_       | out       | modifier_bits, slot_zero .. slot_five    | none
//
//  Flow: one item per cycle while s_tready is high. An item updates the scan
//  registers in the cycle it is accepted; a last item puts its report in the
//  output register on the same edge, so the report shows in the next cycle.
//  Reset: synchronous, active low; clears the scan and drops any held report.
//  Stalls: s_tready falls only while a report waits in the output register
//  and m_tready is low; the output register is the only buffering.
//
module hid_keyboard_report_builder_top #(
    parameter int REPORT_SLOTS = hidkb_pkg::REPORT_SLOTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  hidkb_pkg::usage_t         s_tdata,   // [7:0] key_code
    input  logic                      s_tlast,   // last_key
    // reports
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output hidkb_pkg::report_t        m_tdata    // [7:0] modifier_bits,
                                                 // [15:8] slot_zero .. [55:48] slot_five
);
    import hidkb_pkg::*;

    logic    accept;
    logic    m_tvalid_reg, m_tvalid_next;
    report_t m_tdata_reg;
    report_t report;

    // Take a new item whenever the output register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hidkb_scan #(
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .key_code   (s_tdata),
        .last_key   (s_tlast),
        .report     (report)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept && s_tlast) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the finished report; hold it while the sink stalls
    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            m_tdata_reg <= report;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/hidkb_scan.sv */
// ----------------------------------------------------------------------------
// hidkb_scan
// Folds the usage codes of one scan into the normal and cursor reports.
// ----------------------------------------------------------------------------
module hidkb_scan #(
    parameter int REPORT_SLOTS = hidkb_pkg::REPORT_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  hidkb_pkg::usage_t key_code,
    input  logic              last_key,
    output hidkb_pkg::report_t report
);
    import hidkb_pkg::*;

    localparam int FILL_W = $clog2(REPORT_SLOTS + 1);

    usage_t              mod_reg, mod_next;
    usage_t              norm_reg  [REPORT_SLOTS];
    usage_t              norm_next [REPORT_SLOTS];
    usage_t              cur_reg   [REPORT_SLOTS];
    usage_t              cur_next  [REPORT_SLOTS];
    logic [FILL_W-1:0]   norm_fill_reg, norm_fill_next;
    logic [FILL_W-1:0]   cur_fill_reg, cur_fill_next;
    logic                shift_seen_reg, shift_seen_next;
    logic                arrow_seen_reg, arrow_seen_next;

    logic   is_mod, is_right, is_down, norm_open, cur_open, norm_take, cur_take;
    logic   cursor_mode;
    usage_t cur_code;

    always_comb begin
        is_mod    = (key_code[USAGE_W-1:3] == USAGE_MOD_PREFIX);
        is_right  = (key_code == USAGE_RIGHT);
        is_down   = (key_code == USAGE_DOWN);
        norm_open = (norm_fill_reg < FILL_W'(REPORT_SLOTS));
        cur_open  = (cur_fill_reg < FILL_W'(REPORT_SLOTS));
        norm_take = norm_open && !is_mod;
        cur_take  = cur_open && (is_right || is_down);
        cur_code  = is_right ? USAGE_LEFT : USAGE_UP;

        shift_seen_next = shift_seen_reg ||
                          (key_code == USAGE_LSHIFT) || (key_code == USAGE_RSHIFT);
        arrow_seen_next = arrow_seen_reg || is_right || is_down;

        // Modifiers are dropped too once the slots are full
        mod_next = mod_reg;
        if (norm_open && is_mod) begin
            mod_next[key_code[2:0]] = 1'b1;
        end

        for (int i = 0; i < REPORT_SLOTS; i++) begin
            norm_next[i] = norm_reg[i];
            cur_next[i]  = cur_reg[i];
            if (norm_take && (norm_fill_reg == FILL_W'(i))) begin
                norm_next[i] = key_code;
            end
            if (cur_take && (cur_fill_reg == FILL_W'(i))) begin
                cur_next[i] = cur_code;
            end
        end
        norm_fill_next = norm_fill_reg + FILL_W'(norm_take);
        cur_fill_next  = cur_fill_reg + FILL_W'(cur_take);

        // Report as it stands after this item
        cursor_mode     = shift_seen_next && arrow_seen_next;
        report          = '0;
        report.modifier = cursor_mode ? '0 : mod_next;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            report.slots[i] = cursor_mode ? cur_next[i] : norm_next[i];
        end
    end

    // Clear the scan on reset and after the last item
    always_ff @(posedge aclk) begin
        if (!aresetn || (item_valid && last_key)) begin
            mod_reg        <= '0;
            norm_fill_reg  <= '0;
            cur_fill_reg   <= '0;
            shift_seen_reg <= 1'b0;
            arrow_seen_reg <= 1'b0;
            for (int i = 0; i < REPORT_SLOTS; i++) begin
                norm_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end else if (item_valid) begin
            mod_reg        <= mod_next;
            norm_fill_reg  <= norm_fill_next;
            cur_fill_reg   <= cur_fill_next;
            shift_seen_reg <= shift_seen_next;
            arrow_seen_reg <= arrow_seen_next;
            for (int i = 0; i < REPORT_SLOTS; i++) begin
                norm_reg[i] <= norm_next[i];
                cur_reg[i]  <= cur_next[i];
            end
        end
    end

endmodule

/* rtl/hidkb_checker.sv */
// ----------------------------------------------------------------------------
// hidkb_checker
// Port-level checks on the report builder, bound to the top level.
// ----------------------------------------------------------------------------
module hidkb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input hidkb_pkg::report_t  m_tdata
);
    // A stalled report holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("report changed while stalled");

    // A last item always yields a report next cycle
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no report after last item");

    // Reports appear only after a last item
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("report without last item");

    // A non-last item into an empty output makes no report
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("report from non-last item");

    // Input is taken whenever the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind hid_keyboard_report_builder_top hidkb_checker u_hidkb_checker (.*);
